// ----- src/rds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Package for the recovery deploy sequencer.
// Holds register indexes, reset values, servo positions and bus widths.
// No dependencies.
package rds_pkg;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 16;

    typedef enum logic [2:0] {
        REG_MARKER   = 3'd0,
        REG_ACK      = 3'd1,
        REG_LIFTOFF  = 3'd2,
        REG_APOGEE   = 3'd3,
        REG_DELAY    = 3'd4,
        REG_TIMEOUT  = 3'd5
    } t_reg_idx;

    localparam logic [7:0]  RST_MARKER  = 8'd255;
    localparam logic [7:0]  RST_ACK     = 8'd1;
    localparam logic [7:0]  RST_LIFTOFF = 8'd2;
    localparam logic [7:0]  RST_APOGEE  = 8'd3;
    localparam logic [15:0] RST_DELAY   = 16'd5600;
    localparam logic [15:0] RST_TIMEOUT = 16'd500;

    localparam logic [7:0] SERVO_CLOSED = 8'd10;
    localparam logic [7:0] SERVO_OPEN   = 8'd100;
    localparam logic [7:0] SERVO_CHUTE  = 8'd160;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        FRAME_MARK  = 3'b001,
        FRAME_CODE1 = 3'b010,
        FRAME_CODE2 = 3'b100
    } t_frame_pos;

endpackage : rds_pkg
`default_nettype wire

// ----- src/recovery_deploy_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Recovery deploy sequencer top level: frame parser, hatch lock, liftoff and deploy logic.
// Depends on rds_pkg.
//
// Channel   Direction  Contents
// s_axis    in         one tick: rx_valid, rx_byte, pin_present, hatch_switch
// m_axis    out        one result: servo angle, three LEDs, four send pulses
// APB       in/out     six configuration registers at byte addresses 0 to 20
//
// Each tick request's result is registered into the output register in the cycle after it is accepted.
// A new request is accepted in every cycle while the output register is empty or being taken.
// Reset is synchronous and active low and loads the register defaults.
// A stalled result holds the output register and blocks only further requests.
module recovery_deploy_sequencer
    import rds_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [0] rx_valid, [8:1] rx_byte, [9] pin_present, [10] hatch_switch, [15:11] zero
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] servo_angle, [8] led_hatch, [9] led_liftoff, [10] led_chute,
    // [11] send_liftoff_ack, [12] send_apogee_ack, [13] send_liftoff_notice,
    // [14] send_chute_notice, [15] zero
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    logic [7:0]  r_marker, r_code_ack, r_code_lift, r_code_apo;
    logic [15:0] r_delay, r_timeout;

    t_frame_pos  r_frame_pos, n_frame_pos;
    logic [7:0]  r_first_code, n_first_code;
    logic        r_hatch_locked, n_hatch_locked;
    logic        r_switch_last, n_switch_last;
    logic        r_pin_pulled, n_pin_pulled;
    logic        r_liftoff, n_liftoff;
    logic        r_lift_peer, n_lift_peer;
    logic        r_notice_pend, n_notice_pend;
    logic        r_peer_acked, n_peer_acked;
    logic        r_chute, n_chute;
    logic        r_chute_done, n_chute_done;
    logic [15:0] r_flight, n_flight;
    logic [15:0] r_ack_tmr, n_ack_tmr;
    logic [7:0]  r_servo, n_servo;
    logic [2:0]  r_led, n_led;
    logic [3:0]  n_tx;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic       w_accept;
    logic       w_cfg_wr;
    t_reg_idx   w_cfg_idx;
    logic       w_rx_valid;
    logic [7:0] w_rx_byte;
    logic       w_pin_present;
    logic       w_switch;

    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign w_cfg_idx     = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_rx_valid    = s_axis_tdata[0];
    assign w_rx_byte     = s_axis_tdata[8:1];
    assign w_pin_present = s_axis_tdata[9];
    assign w_switch      = s_axis_tdata[10];

    always_comb begin
        prdata = '0;
        case (w_cfg_idx)
            REG_MARKER:  prdata = {24'd0, r_marker};
            REG_ACK:     prdata = {24'd0, r_code_ack};
            REG_LIFTOFF: prdata = {24'd0, r_code_lift};
            REG_APOGEE:  prdata = {24'd0, r_code_apo};
            REG_DELAY:   prdata = {16'd0, r_delay};
            REG_TIMEOUT: prdata = {16'd0, r_timeout};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker    <= RST_MARKER;
            r_code_ack  <= RST_ACK;
            r_code_lift <= RST_LIFTOFF;
            r_code_apo  <= RST_APOGEE;
            r_delay     <= RST_DELAY;
            r_timeout   <= RST_TIMEOUT;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_MARKER:  r_marker    <= pwdata[7:0];
                REG_ACK:     r_code_ack  <= pwdata[7:0];
                REG_LIFTOFF: r_code_lift <= pwdata[7:0];
                REG_APOGEE:  r_code_apo  <= pwdata[7:0];
                REG_DELAY:   r_delay     <= pwdata[15:0];
                REG_TIMEOUT: r_timeout   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_frame_pos    = r_frame_pos;
        n_first_code   = r_first_code;
        n_hatch_locked = r_hatch_locked;
        n_switch_last  = r_switch_last;
        n_pin_pulled   = r_pin_pulled;
        n_liftoff      = r_liftoff;
        n_lift_peer    = r_lift_peer;
        n_notice_pend  = r_notice_pend;
        n_peer_acked   = r_peer_acked;
        n_chute        = r_chute;
        n_chute_done   = r_chute_done;
        n_servo        = r_servo;
        n_led          = r_led;
        n_tx           = '0;

        n_flight  = (r_liftoff && r_flight != TIMER_MAX) ? r_flight + 16'd1 : r_flight;
        n_ack_tmr = (r_notice_pend && r_ack_tmr != TIMER_MAX) ? r_ack_tmr + 16'd1 : r_ack_tmr;

        if (w_rx_valid) begin
            case (r_frame_pos)
                FRAME_MARK: begin
                    if (w_rx_byte == r_marker) n_frame_pos = FRAME_CODE1;
                end
                FRAME_CODE1: begin
                    n_first_code = w_rx_byte;
                    n_frame_pos  = FRAME_CODE2;
                end
                default: begin
                    n_frame_pos = FRAME_MARK;
                    if (r_first_code == w_rx_byte) begin
                        if (w_rx_byte == r_code_ack) begin
                            n_peer_acked = 1'b1;
                        end else if (w_rx_byte == r_code_lift) begin
                            n_lift_peer = 1'b1;
                            n_tx[0]     = 1'b1;
                        end else if (w_rx_byte == r_code_apo) begin
                            n_chute = 1'b1;
                            n_tx[1] = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (r_pin_pulled && !n_notice_pend && !n_lift_peer) begin
            n_notice_pend = 1'b1;
            n_ack_tmr     = '0;
            n_tx[2]       = 1'b1;
        end
        if (!n_peer_acked && n_notice_pend && n_ack_tmr > r_timeout) n_notice_pend = 1'b0;
        if (n_chute && !r_chute_done) begin
            n_tx[3]      = 1'b1;
            n_chute_done = 1'b1;
        end

        if (!r_liftoff && w_switch != r_switch_last) begin
            n_switch_last = w_switch;
            if (r_hatch_locked) begin
                n_hatch_locked = 1'b0;
                n_servo        = SERVO_OPEN;
                n_led[0]       = 1'b0;
            end else begin
                n_hatch_locked = 1'b1;
                n_servo        = SERVO_CLOSED;
                n_led[0]       = 1'b1;
            end
        end

        if (n_hatch_locked && !r_liftoff && !w_pin_present && !n_lift_peer) begin
            n_liftoff    = 1'b1;
            n_pin_pulled = 1'b1;
            n_flight     = '0;
            n_led[1]     = 1'b1;
        end
        if (n_lift_peer && !n_liftoff) begin
            n_liftoff = 1'b1;
            n_flight  = '0;
            n_led[1]  = 1'b1;
        end

        if (n_liftoff && (n_flight > r_delay || n_chute)) begin
            n_servo  = SERVO_CHUTE;
            n_led[2] = 1'b1;
            n_led[0] = 1'b0;
            n_chute  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pos    <= FRAME_MARK;
            r_first_code   <= '0;
            r_hatch_locked <= 1'b0;
            r_switch_last  <= 1'b0;
            r_pin_pulled   <= 1'b0;
            r_liftoff      <= 1'b0;
            r_lift_peer    <= 1'b0;
            r_notice_pend  <= 1'b0;
            r_peer_acked   <= 1'b0;
            r_chute        <= 1'b0;
            r_chute_done   <= 1'b0;
            r_flight       <= '0;
            r_ack_tmr      <= '0;
            r_servo        <= SERVO_CLOSED;
            r_led          <= '0;
        end else if (w_accept) begin
            r_frame_pos    <= n_frame_pos;
            r_first_code   <= n_first_code;
            r_hatch_locked <= n_hatch_locked;
            r_switch_last  <= n_switch_last;
            r_pin_pulled   <= n_pin_pulled;
            r_liftoff      <= n_liftoff;
            r_lift_peer    <= n_lift_peer;
            r_notice_pend  <= n_notice_pend;
            r_peer_acked   <= n_peer_acked;
            r_chute        <= n_chute;
            r_chute_done   <= n_chute_done;
            r_flight       <= n_flight;
            r_ack_tmr      <= n_ack_tmr;
            r_servo        <= n_servo;
            r_led          <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {1'b0, n_tx, n_led, n_servo};
        end
    end

`ifndef SYNTHESIS
    a_chute_servo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led[2] |-> (r_servo == SERVO_CHUTE && !r_led[0]))
        else $error("chute LED set without chute servo position");

    a_liftoff_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led[1] == r_liftoff)
        else $error("liftoff LED disagrees with liftoff state");

    a_liftoff_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_liftoff |=> r_liftoff)
        else $error("liftoff state was cleared");

    a_chute_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_chute_done) |=> !r_out_data[14])
        else $error("chute notice sent more than once");
`endif

endmodule : recovery_deploy_sequencer
`default_nettype wire
